[rtl/assert_macros.svh]
// Assertion helpers used by lifegen_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is held.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    `ASSERT_CLK(label, clk, rstn, !(cond))

`endif

[rtl/lifegen_pkg.sv]
// ----------------------------------------------------------------------------
// lifegen_pkg
// Shared types and constants of the life generation step block.
// ----------------------------------------------------------------------------
`default_nettype none

package lifegen_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_NOP   = 2'd3
    } lifegen_op_t;

    typedef enum logic {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } lifegen_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_MOD,
        ST_GEN_PRE0,
        ST_GEN_PRE1,
        ST_GEN_PRE2,
        ST_GEN_ROW,
        ST_DONE
    } lifegen_state_t;

    typedef struct packed {
        logic        valid;
        logic        read_value;
        logic [1:0]  opcode;
    } lifegen_result_t;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;
    localparam int         MIN_SIZE      = 3;
    localparam logic [6:0] SIZE_RESET    = 7'd64;

endpackage

`default_nettype wire

[rtl/lifegen_row_mem.sv]
// ----------------------------------------------------------------------------
// lifegen_row_mem
// Grid storage, one row of cells per word; one write port and one read port
// with registered read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module lifegen_row_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/lifegen_row_rule.sv]
// ----------------------------------------------------------------------------
// lifegen_row_rule
// B3/S23 update of one full row: one lane per column, horizontal wrap at the
// active column count, columns outside the active region pass through.
// ----------------------------------------------------------------------------
`default_nettype none

module lifegen_row_rule #(
    parameter int MAX_COLUMNS = 64,
    localparam int CIW = $clog2(MAX_COLUMNS + 1),
    localparam int CAW = $clog2(MAX_COLUMNS)
) (
    input  wire logic [CIW-1:0]         cols_use,
    input  wire logic [MAX_COLUMNS-1:0] prior_row,
    input  wire logic [MAX_COLUMNS-1:0] cur_row,
    input  wire logic [MAX_COLUMNS-1:0] below_row,
    output logic      [MAX_COLUMNS-1:0] next_row
);
    import lifegen_pkg::*;

    logic [CAW-1:0] last_col;
    logic           p_last;
    logic           c_last;
    logic           b_last;

    assign last_col = CAW'(cols_use - 1'b1);
    assign p_last   = prior_row[last_col];
    assign c_last   = cur_row[last_col];
    assign b_last   = below_row[last_col];

    for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_lane
        localparam logic [CIW-1:0] LANE = CIW'(c);
        logic       pl, pr, cl, cr, bl, br;
        logic [3:0] n;

        if (c == 0) begin : g_left_wrap
            assign pl = p_last;
            assign cl = c_last;
            assign bl = b_last;
        end else begin : g_left
            assign pl = prior_row[c-1];
            assign cl = cur_row[c-1];
            assign bl = below_row[c-1];
        end

        if (c == MAX_COLUMNS - 1) begin : g_right_wrap
            assign pr = prior_row[0];
            assign cr = cur_row[0];
            assign br = below_row[0];
        end else begin : g_right
            logic wrap_r;
            assign wrap_r = (LANE == cols_use - 1'b1);
            assign pr = wrap_r ? prior_row[0] : prior_row[c+1];
            assign cr = wrap_r ? cur_row[0]   : cur_row[c+1];
            assign br = wrap_r ? below_row[0] : below_row[c+1];
        end

        assign n = 4'(pl) + 4'(prior_row[c]) + 4'(pr)
                 + 4'(cl) + 4'(cr)
                 + 4'(bl) + 4'(below_row[c]) + 4'(br);

        assign next_row[c] = (LANE < cols_use)
                           ? ((n == BIRTH_COUNT) || (cur_row[c] && (n == SURVIVE_COUNT)))
                           : cur_row[c];
    end

endmodule

`default_nettype wire

[rtl/lifegen_ctrl.sv]
// ----------------------------------------------------------------------------
// lifegen_ctrl
// Sequencer: clearing pass, single-cell read-modify-write, and the row by row
// generation sweep with prior, current and saved top row registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lifegen_ctrl #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS = 64,
    localparam int CIW = $clog2(MAX_COLUMNS + 1),
    localparam int RIW = $clog2(MAX_ROWS + 1),
    localparam int CAW = $clog2(MAX_COLUMNS),
    localparam int AW  = $clog2(MAX_ROWS)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_opcode,
    input  wire logic [5:0]                    s_col_index,
    input  wire logic [5:0]                    s_row_index,
    input  wire logic                          s_write_value,
    input  wire logic [CIW-1:0]                cols_use,
    input  wire logic [RIW-1:0]                rows_use,
    output lifegen_pkg::lifegen_result_t       res,
    input  wire logic                          slot_free,
    output logic                               wr_en,
    output logic      [AW-1:0]                 wr_addr,
    output logic      [MAX_COLUMNS-1:0]        wr_data,
    output logic      [AW-1:0]                 rd_addr,
    input  wire logic [MAX_COLUMNS-1:0]        rd_data
);
    import lifegen_pkg::*;

    localparam int IXW = (CIW > 6) ? CIW : 6;
    localparam int IYW = (RIW > 6) ? RIW : 6;

    lifegen_state_t state_reg, state_next;

    logic [AW-1:0]          row_cnt_reg;
    logic [1:0]             item_op_reg;
    logic [5:0]             item_col_reg;
    logic [5:0]             item_row_reg;
    logic                   item_wv_reg;
    logic                   rv_reg;
    logic [MAX_COLUMNS-1:0] prior_reg;
    logic [MAX_COLUMNS-1:0] cur_reg;
    logic [MAX_COLUMNS-1:0] top_reg;

    logic [MAX_COLUMNS-1:0] below_row;
    logic [MAX_COLUMNS-1:0] rule_row;
    logic [MAX_COLUMNS-1:0] cell_row;
    logic [AW-1:0]          item_row_addr;
    logic [CAW-1:0]         item_col_bit;
    logic                   in_view;
    logic                   last_row;
    logic                   clear_last;
    logic                   step_req;
    logic                   sweep_end;

    assign item_row_addr = AW'(item_row_reg);
    assign item_col_bit  = CAW'(item_col_reg);
    assign in_view       = (IXW'(item_col_reg) < IXW'(cols_use))
                        && (IYW'(item_row_reg) < IYW'(rows_use));
    assign last_row      = (RIW'(row_cnt_reg) == rows_use - 1'b1);
    assign clear_last    = (row_cnt_reg == AW'(MAX_ROWS - 1));
    assign step_req      = s_valid && s_ready && (s_opcode == OP_STEP);
    assign sweep_end     = (state_reg == ST_GEN_ROW) && last_row;

    // last row of the sweep sees the old row 0 from the saved copy
    assign below_row = last_row ? top_reg : rd_data;

    lifegen_row_rule #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_rule (
        .cols_use  (cols_use),
        .prior_row (prior_reg),
        .cur_row   (cur_reg),
        .below_row (below_row),
        .next_row  (rule_row)
    );

    always_comb begin
        cell_row = rd_data;
        cell_row[item_col_bit] = item_wv_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_opcode)
                        OP_WRITE, OP_READ: state_next = ST_CELL_RD;
                        OP_STEP:           state_next = ST_GEN_PRE0;
                        default:           state_next = ST_DONE;
                    endcase
                end
            end
            ST_CELL_RD:  state_next = ST_CELL_MOD;
            ST_CELL_MOD: state_next = ST_DONE;
            ST_GEN_PRE0: state_next = ST_GEN_PRE1;
            ST_GEN_PRE1: state_next = ST_GEN_PRE2;
            ST_GEN_PRE2: state_next = ST_GEN_ROW;
            ST_GEN_ROW: begin
                if (last_row) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        s_ready        = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = row_cnt_reg;
        wr_data        = rule_row;
        res.valid      = 1'b0;
        res.read_value = rv_reg;
        res.opcode     = item_op_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '0;
            end
            ST_IDLE: s_ready = 1'b1;
            ST_CELL_RD: rd_addr = item_row_addr;
            ST_CELL_MOD: begin
                rd_addr = item_row_addr;
                wr_en   = (item_op_reg == OP_WRITE) && in_view;
                wr_addr = item_row_addr;
                wr_data = cell_row;
            end
            ST_GEN_PRE0: rd_addr = AW'(rows_use - 1'b1);
            ST_GEN_PRE1: rd_addr = '0;
            ST_GEN_PRE2: rd_addr = AW'(1);
            ST_GEN_ROW: begin
                // fetch two ahead: row r+1 is already in rd_data
                rd_addr = row_cnt_reg + AW'(2);
                wr_en   = 1'b1;
            end
            ST_DONE: res.valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            row_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_CLEAR:    row_cnt_reg <= clear_last ? '0 : row_cnt_reg + 1'b1;
                ST_GEN_PRE2: row_cnt_reg <= '0;
                ST_GEN_ROW:  row_cnt_reg <= row_cnt_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_op_reg  <= s_opcode;
                    item_col_reg <= s_col_index;
                    item_row_reg <= s_row_index;
                    item_wv_reg  <= s_write_value;
                    rv_reg       <= 1'b0;
                end
            end
            ST_CELL_MOD: begin
                rv_reg <= (item_op_reg == OP_READ) && in_view && rd_data[item_col_bit];
            end
            ST_GEN_PRE1: prior_reg <= rd_data;
            ST_GEN_PRE2: begin
                top_reg <= rd_data;
                cur_reg <= rd_data;
            end
            ST_GEN_ROW: begin
                prior_reg <= cur_reg;
                cur_reg   <= below_row;
            end
            default: ;
        endcase
    end

    `ASSERT_CLK(a_step_starts, aclk, aresetn, step_req |=> (state_reg == ST_GEN_PRE0))
    `ASSERT_NEVER(a_no_write_when_ready, aclk, aresetn, wr_en && s_ready)
    `ASSERT_CLK(a_result_holds, aclk, aresetn, (res.valid && !slot_free) |=> res.valid)
    `ASSERT_CLK(a_sweep_ends, aclk, aresetn, sweep_end |=> (state_reg == ST_DONE))

endmodule

`default_nettype wire

[rtl/life_automaton_generation_step.sv]
// Flow: a cell write or read passes a read state and a modify state; a generation
// step loads the rows around row 0, then sweeps the grid (one full row read,
// updated and written per cycle). One request in flight: a new one is taken once
// the result is in the output register; the flow stalls only while that register is full.
// Reset: synchronous, active low; then a clearing pass over all MAX_ROWS rows
// zeroes the grid with s_ready low (configuration writes still taken).
// ----------------------------------------------------------------------------
// life_automaton_generation_step
// B3/S23 life automaton on a toroidal grid held in a row-wide memory, with
// single-cell write/read requests and an APB port for the active grid size.
// ----------------------------------------------------------------------------
`default_nettype none

module life_automaton_generation_step #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [5:0]  s_col_index,
    input  wire logic [5:0]  s_row_index,
    input  wire logic        s_write_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_read_value,
    output logic [1:0]       m_done_opcode
);
    import lifegen_pkg::*;

    localparam int CIW = $clog2(MAX_COLUMNS + 1);
    localparam int RIW = $clog2(MAX_ROWS + 1);
    localparam int AW  = $clog2(MAX_ROWS);
    localparam int SWC = (CIW > 7) ? CIW : 7;
    localparam int SWR = (RIW > 7) ? RIW : 7;

    logic [6:0]             cols_reg;
    logic [6:0]             rows_reg;
    logic [CIW-1:0]         cols_use;
    logic [RIW-1:0]         rows_use;
    logic                   cfg_wr;

    logic                   m_valid_reg;
    logic                   m_read_value_reg;
    logic [1:0]             m_done_opcode_reg;
    logic                   slot_free;
    lifegen_result_t        res;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [MAX_COLUMNS-1:0] wr_data;
    logic [AW-1:0]          rd_addr;
    logic [MAX_COLUMNS-1:0] rd_data;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= SIZE_RESET;
            rows_reg <= SIZE_RESET;
        end else if (cfg_wr) begin
            unique case (lifegen_reg_t'(paddr[2]))
                REG_COLUMNS: cols_reg <= pwdata[6:0];
                REG_ROWS:    rows_reg <= pwdata[6:0];
            endcase
        end
    end

    always_comb begin
        unique case (lifegen_reg_t'(paddr[2]))
            REG_COLUMNS: prdata = 32'(cols_reg);
            REG_ROWS:    prdata = 32'(rows_reg);
        endcase
    end

    // registers keep what was written; the size in use is clamped
    always_comb begin
        priority if (SWC'(cols_reg) < SWC'(MIN_SIZE)) begin
            cols_use = CIW'(MIN_SIZE);
        end else if (SWC'(cols_reg) > SWC'(MAX_COLUMNS)) begin
            cols_use = CIW'(MAX_COLUMNS);
        end else begin
            cols_use = CIW'(cols_reg);
        end
    end

    always_comb begin
        priority if (SWR'(rows_reg) < SWR'(MIN_SIZE)) begin
            rows_use = RIW'(MIN_SIZE);
        end else if (SWR'(rows_reg) > SWR'(MAX_ROWS)) begin
            rows_use = RIW'(MAX_ROWS);
        end else begin
            rows_use = RIW'(rows_reg);
        end
    end

    lifegen_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_col_index   (s_col_index),
        .s_row_index   (s_row_index),
        .s_write_value (s_write_value),
        .cols_use      (cols_use),
        .rows_use      (rows_use),
        .res           (res),
        .slot_free     (slot_free),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    lifegen_row_mem #(
        .DEPTH (MAX_ROWS),
        .WIDTH (MAX_COLUMNS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register
    assign slot_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (slot_free) begin
            m_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && res.valid) begin
            m_read_value_reg  <= res.read_value;
            m_done_opcode_reg <= res.opcode;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_done_opcode = m_done_opcode_reg;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life generation step testbench
// Drives write, read, step and no-op requests into the B3/S23 grid block,
// changes the active grid size over APB between phases, and checks every
// result against a toroidal life model kept in the testbench.
// ----------------------------------------------------------------------------

module testbench;

    import lifegen_pkg::*;

    localparam int GRID_COLS      = 64;
    localparam int GRID_ROWS      = 64;
    localparam int BORN_NEIGHBORS = 3;
    localparam int KEEP_NEIGHBORS = 2;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct {
        logic       read_value;
        logic [1:0] done_opcode;
    } cell_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = OP_NOP;
    logic [5:0]  s_col_index = '0;
    logic [5:0]  s_row_index = '0;
    logic        s_write_value = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_read_value;
    logic [1:0]  m_done_opcode;

    life_automaton_generation_step dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_col_index   (s_col_index),
        .s_row_index   (s_row_index),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_done_opcode (m_done_opcode)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Model state: one 64-bit word per row, bit index = column.
    logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
    logic [6:0]           columns_reg = SIZE_RESET;
    logic [6:0]           rows_reg = SIZE_RESET;

    cell_result_t pending_results [$];
    cell_result_t seen_result;
    int unsigned  error_count;
    int unsigned  results_checked;
    int unsigned  writes_sent, reads_sent, steps_sent, nops_sent, size_changes;
    int unsigned  burst_left;

    function automatic int active_size(logic [6:0] raw, int limit);
        if (raw < MIN_SIZE) return MIN_SIZE;
        if (raw > limit) return limit;
        return int'(raw);
    endfunction

    function automatic void step_generation();
        logic [GRID_COLS-1:0] prev_gen [GRID_ROWS];
        int cols;
        int rows;
        int n;
        cols = active_size(columns_reg, GRID_COLS);
        rows = active_size(rows_reg, GRID_ROWS);
        for (int r = 0; r < GRID_ROWS; r++) prev_gen[r] = life_grid[r];
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0)
                            n += prev_gen[(r + dr + rows) % rows][(c + dc + cols) % cols];
                    end
                end
                life_grid[r][c] = (n == BORN_NEIGHBORS) ||
                                  (prev_gen[r][c] && n == KEEP_NEIGHBORS);
            end
        end
    endfunction

    function automatic cell_result_t apply_cell_request(lifegen_op_t op, logic [5:0] col,
                                                        logic [5:0] row, logic wv);
        cell_result_t res;
        logic in_view;
        in_view = (col < active_size(columns_reg, GRID_COLS)) &&
                  (row < active_size(rows_reg, GRID_ROWS));
        res.read_value  = 1'b0;
        res.done_opcode = op;
        case (op)
            OP_WRITE: if (in_view) life_grid[row][col] = wv;
            OP_READ:  if (in_view) res.read_value = life_grid[row][col];
            OP_STEP:  step_generation();
            default:  ;
        endcase
        return res;
    endfunction

    // One request on the input channel; valid stays up across a burst.
    task automatic send_request(lifegen_op_t op, logic [5:0] col, logic [5:0] row, logic wv);
        int unsigned gap;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_col_index   <= col;
        s_row_index   <= row;
        s_write_value <= wv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_cell_request(op, col, row, wv));
        case (op)
            OP_WRITE: writes_sent++;
            OP_READ:  reads_sent++;
            OP_STEP:  steps_sent++;
            default:  nops_sent++;
        endcase
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write then read back; the register keeps the low 7 bits as written.
    task automatic set_size_reg(lifegen_reg_t idx, logic [31:0] value);
        logic [31:0] readback;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_COLUMNS) columns_reg = value[6:0];
        else rows_reg = value[6:0];
        size_changes++;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[6:0] !== value[6:0]) begin
            $display("%0t ns: size register %s readback expected %0d actual %0d",
                     $time, idx.name(), value[6:0], readback[6:0]);
            error_count++;
        end
    endtask

    task automatic set_grid_size(logic [31:0] cols, logic [31:0] rows);
        wait_idle();
        set_size_reg(REG_COLUMNS, cols);
        set_size_reg(REG_ROWS, rows);
    endtask

    // Receiver: holds one ready behavior for a while, then picks another.
    int unsigned ready_mode, ready_hold;
    always @(negedge aclk) begin
        if (ready_hold == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(16, 160);
        end else begin
            ready_hold--;
        end
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 5) == 0);
            default: m_ready <= (ready_hold % 9) < 5;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual read_value %0b done_opcode %0d",
                         $time, m_read_value, m_done_opcode);
                error_count++;
            end else begin
                seen_result = pending_results.pop_front();
                results_checked++;
                if (m_read_value !== seen_result.read_value) begin
                    $display("%0t ns: read_value expected %0b actual %0b",
                             $time, seen_result.read_value, m_read_value);
                    error_count++;
                end
                if (m_done_opcode !== seen_result.done_opcode) begin
                    $display("%0t ns: done_opcode expected %0d actual %0d",
                             $time, seen_result.done_opcode, m_done_opcode);
                    error_count++;
                end
            end
        end
    end

    task automatic test_register_access();
        // upper write-data bits must not leak into the stored value
        set_size_reg(REG_COLUMNS, 32'hFFFF_FF83);
        set_size_reg(REG_ROWS, 32'h0000_0040);
        set_size_reg(REG_COLUMNS, 32'd64);
    endtask

    task automatic test_cell_extremes();
        send_request(OP_WRITE, 6'd0, 6'd0, 1'b1);
        send_request(OP_WRITE, 6'd63, 6'd63, 1'b1);
        send_request(OP_WRITE, 6'd0, 6'd63, 1'b1);
        send_request(OP_WRITE, 6'd63, 6'd0, 1'b0);
        send_request(OP_READ, 6'd0, 6'd0, 1'b0);
        send_request(OP_READ, 6'd63, 6'd63, 1'b1);
        send_request(OP_READ, 6'd0, 6'd63, 1'b0);
        send_request(OP_READ, 6'd63, 6'd0, 1'b0);
        send_request(OP_WRITE, 6'd0, 6'd0, 1'b0);
        send_request(OP_NOP, 6'd63, 6'd63, 1'b1);
        send_request(OP_NOP, 6'd0, 6'd0, 1'b0);
    endtask

    task automatic test_size_clamping();
        // below minimum clamps to 3x3, above maximum to 64x64
        set_grid_size(32'd0, 32'd2);
        send_request(OP_WRITE, 6'd2, 6'd2, 1'b1);
        send_request(OP_WRITE, 6'd3, 6'd0, 1'b1);
        send_request(OP_READ, 6'd3, 6'd0, 1'b0);
        send_request(OP_STEP, 6'd0, 6'd0, 1'b0);
        set_grid_size(32'd127, 32'd65);
        send_request(OP_READ, 6'd63, 6'd63, 1'b0);
        send_request(OP_READ, 6'd2, 6'd2, 1'b0);
    endtask

    task automatic test_region_shrink();
        // lone cell at the far corner must survive steps while out of view
        send_request(OP_WRITE, 6'd63, 6'd63, 1'b1);
        set_grid_size(32'd10, 32'd12);
        send_request(OP_WRITE, 6'd5, 6'd4, 1'b1);
        send_request(OP_WRITE, 6'd5, 6'd5, 1'b1);
        send_request(OP_WRITE, 6'd5, 6'd6, 1'b1);
        send_request(OP_WRITE, 6'd20, 6'd2, 1'b1);
        send_request(OP_STEP, 6'd0, 6'd0, 1'b0);
        send_request(OP_READ, 6'd4, 6'd5, 1'b0);
        send_request(OP_READ, 6'd63, 6'd63, 1'b0);
        send_request(OP_STEP, 6'd0, 6'd0, 1'b0);
        set_grid_size(32'd64, 32'd64);
        send_request(OP_READ, 6'd63, 6'd63, 1'b0);
        send_request(OP_READ, 6'd20, 6'd2, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        int cols, rows;
        logic [5:0] col, row;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_grid_size($urandom_range(3, 8), $urandom_range(3, 8));
                1: set_grid_size($urandom_range(9, 20), $urandom_range(3, 16));
                2: set_grid_size(32'd3, 32'd64);
                3: set_grid_size(32'd64, 32'd3);
                default: set_grid_size($urandom_range(0, 127), $urandom_range(0, 127));
            endcase
            cols = active_size(columns_reg, GRID_COLS);
            rows = active_size(rows_reg, GRID_ROWS);
            for (int i = 0; i < 22; i++) begin
                pick = $urandom_range(0, 99);
                // mostly inside the active region so that patterns build up
                if ($urandom_range(0, 7) == 0) begin
                    col = 6'($urandom_range(0, 63));
                    row = 6'($urandom_range(0, 63));
                end else begin
                    col = 6'($urandom_range(0, cols - 1));
                    row = 6'($urandom_range(0, rows - 1));
                end
                if (pick < 45)
                    send_request(OP_WRITE, col, row, $urandom_range(0, 3) != 0);
                else if (pick < 80)
                    send_request(OP_READ, col, row, 1'($urandom_range(0, 1)));
                else if (pick < 94)
                    send_request(OP_STEP, col, row, 1'($urandom_range(0, 1)));
                else
                    send_request(OP_NOP, col, row, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        for (int r = 0; r < GRID_ROWS; r++) life_grid[r] = '0;
        burst_left = $urandom_range(1, 24);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_register_access();
        test_cell_extremes();
        test_size_clamping();
        test_region_shrink();
        test_random_traffic();
        wait_idle();
        $display("Sent %0d requests: %0d writes, %0d reads, %0d steps, %0d no-ops",
                 writes_sent + reads_sent + steps_sent + nops_sent,
                 writes_sent, reads_sent, steps_sent, nops_sent);
        $display("%0d results checked across %0d size register writes, incl. clamped values",
                 results_checked, size_changes);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
